// ===== src/glb_pkg.sv =====
// Shared types and constants for the greedy line breaker.
// Used by every module in src; has no dependencies of its own.
`default_nettype none

package glb_pkg;

    localparam int CLS_W       = 3;
    localparam int GLYPH_W     = 8;
    localparam int OFFSET_BITS = 16;
    localparam int PIX_W       = 16;
    localparam int SUM_W       = PIX_W + 1;

    localparam logic [PIX_W-1:0] AVAIL_RESET = PIX_W'(320);
    localparam logic [PIX_W-1:0] PIX_MAX     = {PIX_W{1'b1}};

    typedef enum logic [CLS_W-1:0] {
        CLS_ORDINARY = 3'd0,
        CLS_SPACE    = 3'd1,
        CLS_HYPHEN   = 3'd2,
        CLS_NEWLINE  = 3'd3,
        CLS_CR       = 3'd4,
        CLS_END      = 3'd5
    } char_class_t;

    typedef struct packed {
        logic [CLS_W-1:0]       cls;
        logic [GLYPH_W-1:0]     glyph;
        logic [OFFSET_BITS-1:0] offset;
    } item_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] length;
        logic [PIX_W-1:0]       pixels;
    } line_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] line_start;
        logic [PIX_W-1:0]       line_width;
        logic [OFFSET_BITS-1:0] brk_pos;
        logic [GLYPH_W-1:0]     brk_glyph;
        logic [PIX_W-1:0]       brk_width;
        logic                   brk_skipped;
    } line_state_t;

    // Handshake between the item stage, the core and the result stage.
    typedef struct packed {
        logic item_vld;
        logic emit;
        logic adv;
    } pipe_ctrl_t;

endpackage

`default_nettype wire

// ===== src/greedy_line_breaker_unit.sv =====
// Top level of the greedy line breaker: input stage, core and result stage.
// Depends on glb_pkg, glb_in_stage, glb_core and glb_out_stage.
//
// Usage:
// - Input channel (in_valid / in_stall) carries one classified codepoint per
//   transfer: char_class, glyph_width and byte_offset.
// - Output channel (out_valid / out_stall) carries one emitted line per
//   transfer: line_start, line_length and line_pixels. Most codepoints emit
//   nothing; newline always emits, end of text emits a non-empty last line.
// - cfg_write with cfg_data sets the available line width in pixels. Write it
//   only while no codepoint is in flight.
// - A line passes the input register and then the result register, where
//   out_valid rises; a stalled result can hold it back. One codepoint is taken
//   every cycle while in_stall is low; the line state updates straight from the
//   input register, so back-to-back items need no bubbles.
// - A stalled result stays in the result register. Items that emit nothing
//   keep flowing behind it; the first item that would emit waits in the input
//   register, and in_stall rises until the result is taken.
// - Reset clears the line state and both stages and sets the available width
//   to 320 pixels.
`default_nettype none

module greedy_line_breaker_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [glb_pkg::PIX_W-1:0]         cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [glb_pkg::CLS_W-1:0]         char_class,
    input  wire logic [glb_pkg::GLYPH_W-1:0]       glyph_width,
    input  wire logic [glb_pkg::OFFSET_BITS-1:0]   byte_offset,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [glb_pkg::OFFSET_BITS-1:0]        line_start,
    output logic [glb_pkg::OFFSET_BITS-1:0]        line_length,
    output logic [glb_pkg::PIX_W-1:0]              line_pixels
);

    logic [glb_pkg::PIX_W-1:0] avail_reg;
    logic                      item_vld;
    logic                      adv;
    logic                      emit;
    glb_pkg::item_t            item;
    glb_pkg::line_t            result;
    glb_pkg::pipe_ctrl_t       ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avail_reg <= glb_pkg::AVAIL_RESET;
        end
        else if (cfg_write)
        begin
            avail_reg <= cfg_data;
        end
    end

    glb_in_stage u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_class  (char_class),
        .glyph_width (glyph_width),
        .byte_offset (byte_offset),
        .adv         (adv),
        .item_vld    (item_vld),
        .item        (item)
    );

    glb_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .avail  (avail_reg),
        .item   (item),
        .adv    (adv),
        .emit   (emit),
        .result (result)
    );

    assign ctrl.item_vld = item_vld;
    assign ctrl.emit     = emit;
    assign ctrl.adv      = adv;

    glb_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .result      (result),
        .can_adv     (adv),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .line_start  (line_start),
        .line_length (line_length),
        .line_pixels (line_pixels)
    );

    // A line leaving the core must show up on the output in the next cycle.
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        adv && emit |=> out_valid)
        else $error("emitted line did not reach the result register");

    // The input side waits only behind a stalled result and an emitting item.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (item_vld && out_valid && out_stall && emit))
        else $error("input stalled without a blocked result");

    // Never overwrite a result that the receiver has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        adv && emit |-> !(out_valid && out_stall))
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// ===== src/glb_in_stage.sv =====
// Input register of the line breaker: captures one codepoint per transfer.
// Depends on glb_pkg for the item type.
`default_nettype none

module glb_in_stage (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [glb_pkg::CLS_W-1:0]         char_class,
    input  wire logic [glb_pkg::GLYPH_W-1:0]       glyph_width,
    input  wire logic [glb_pkg::OFFSET_BITS-1:0]   byte_offset,
    input  wire logic                              adv,
    output logic                                   item_vld,
    output glb_pkg::item_t                         item
);

    logic           vld_reg;
    logic           vld_next;
    logic           accept;
    glb_pkg::item_t item_reg;

    // The held item blocks a new transfer only when it cannot move on.
    assign in_stall = vld_reg & ~adv;
    assign accept   = in_valid & ~in_stall;
    assign vld_next = accept | (vld_reg & ~adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.cls    <= char_class;
            item_reg.glyph  <= glyph_width;
            item_reg.offset <= byte_offset;
        end
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule

`default_nettype wire

// ===== src/glb_core.sv =====
// Line state registers and the per-codepoint wrap decision.
// Depends on glb_pkg for types, class codes and widths.
`default_nettype none

module glb_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [glb_pkg::PIX_W-1:0]   avail,
    input  wire glb_pkg::item_t              item,
    input  wire logic                        adv,
    output logic                             emit,
    output glb_pkg::line_t                   result
);

    glb_pkg::line_state_t st_reg;
    glb_pkg::line_state_t st_next;

    logic [glb_pkg::SUM_W-1:0]       sum;
    logic [glb_pkg::SUM_W-1:0]       cut;
    logic [glb_pkg::SUM_W-1:0]       rest;
    logic [glb_pkg::OFFSET_BITS-1:0] ofs_plus1;
    logic [glb_pkg::OFFSET_BITS-1:0] ofs_len;
    logic [glb_pkg::PIX_W-1:0]       brk_px;
    logic                            fits;
    logic                            has_brk;
    logic                            width_nz;

    assign sum       = {1'b0, st_reg.line_width} + glb_pkg::SUM_W'(item.glyph);
    assign cut       = {1'b0, st_reg.brk_width} + glb_pkg::SUM_W'(st_reg.brk_glyph);
    assign rest      = (sum >= cut) ? (sum - cut) : '0;
    assign fits      = sum <= {1'b0, avail};
    assign has_brk   = st_reg.brk_pos > st_reg.line_start;
    assign width_nz  = st_reg.line_width != '0;
    assign ofs_plus1 = item.offset + glb_pkg::OFFSET_BITS'(1);
    assign ofs_len   = item.offset - st_reg.line_start;
    assign brk_px    = st_reg.brk_skipped ? st_reg.brk_width
                     : st_reg.brk_width + glb_pkg::PIX_W'(st_reg.brk_glyph);

    always_comb
    begin
        st_next       = st_reg;
        emit          = 1'b0;
        result.start  = st_reg.line_start;
        result.length = ofs_len;
        result.pixels = st_reg.line_width;

        case (item.cls) inside
            glb_pkg::CLS_NEWLINE:
            begin
                emit = 1'b1;
                if (!width_nz)
                begin
                    result.length = '0;
                end
                st_next.line_start = ofs_plus1;
                st_next.line_width = '0;
                st_next.brk_pos    = '0;
                st_next.brk_width  = '0;
            end
            glb_pkg::CLS_END:
            begin
                emit    = width_nz;
                st_next = '0;
            end
            glb_pkg::CLS_ORDINARY, glb_pkg::CLS_SPACE, glb_pkg::CLS_HYPHEN:
            begin
                if (!fits)
                begin
                    st_next.brk_pos   = '0;
                    st_next.brk_width = '0;
                    if (item.cls == glb_pkg::CLS_SPACE)
                    begin
                        // A space that overflows ends the line and is dropped.
                        emit               = width_nz;
                        st_next.line_start = ofs_plus1;
                        st_next.line_width = '0;
                    end
                    else if (has_brk)
                    begin
                        // Wrap at the last break; the tail after it moves down.
                        emit          = st_reg.brk_width != '0;
                        result.length = st_reg.brk_pos - st_reg.line_start
                                      + glb_pkg::OFFSET_BITS'(!st_reg.brk_skipped);
                        result.pixels = brk_px;
                        st_next.line_start = st_reg.brk_pos + glb_pkg::OFFSET_BITS'(1);
                        st_next.line_width = rest[glb_pkg::PIX_W] ? glb_pkg::PIX_MAX
                                           : rest[glb_pkg::PIX_W-1:0];
                    end
                    else
                    begin
                        // Hard cut: this glyph opens the next line.
                        emit               = width_nz;
                        st_next.line_start = item.offset;
                        st_next.line_width = glb_pkg::PIX_W'(item.glyph);
                    end
                end
                else if (item.cls != glb_pkg::CLS_ORDINARY && width_nz)
                begin
                    st_next.brk_skipped = item.cls == glb_pkg::CLS_SPACE;
                    st_next.brk_pos     = item.offset;
                    st_next.brk_width   = st_reg.line_width;
                    st_next.brk_glyph   = item.glyph;
                    st_next.line_width  = sum[glb_pkg::PIX_W-1:0];
                end
                else if (item.cls == glb_pkg::CLS_SPACE)
                begin
                    // Leading space: skip it and start the line after it.
                    st_next.brk_skipped = 1'b1;
                    st_next.line_start  = ofs_plus1;
                    st_next.line_width  = '0;
                    st_next.brk_pos     = '0;
                    st_next.brk_width   = '0;
                end
                else
                begin
                    st_next.line_width = sum[glb_pkg::PIX_W-1:0];
                end
            end
            default:
            begin
                st_next = st_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (adv)
        begin
            st_reg <= st_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/glb_out_stage.sv =====
// Result register of the line breaker: holds one emitted line until taken.
// Depends on glb_pkg for the line type and control struct.
`default_nettype none

module glb_out_stage (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire glb_pkg::pipe_ctrl_t                ctrl,
    input  wire glb_pkg::line_t                     result,
    output logic                                    can_adv,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [glb_pkg::OFFSET_BITS-1:0]         line_start,
    output logic [glb_pkg::OFFSET_BITS-1:0]         line_length,
    output logic [glb_pkg::PIX_W-1:0]               line_pixels
);

    logic           vld_reg;
    logic           vld_next;
    logic           load;
    glb_pkg::line_t line_reg;

    // An item with no result may pass even while the register is full.
    assign can_adv  = ctrl.item_vld & (~vld_reg | ~out_stall | ~ctrl.emit);
    assign load     = ctrl.adv & ctrl.emit;
    assign vld_next = load | (vld_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            line_reg <= result;
        end
    end

    assign out_valid   = vld_reg;
    assign line_start  = line_reg.start;
    assign line_length = line_reg.length;
    assign line_pixels = line_reg.pixels;

endmodule

`default_nettype wire
